/* rtl/slip_frame_receiver_with_header_check_defines.svh */
// Assertion macros shared by the SLIP receiver checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SLIP_FRAME_RECEIVER_WITH_HEADER_CHECK_DEFINES_SVH
`define SLIP_FRAME_RECEIVER_WITH_HEADER_CHECK_DEFINES_SVH

// Checked at every clock edge outside reset.
`define SFRHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sfrhc: property violated");

// Checked at every clock edge, reset included.
`define SFRHC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sfrhc: property violated during or after reset");

`endif

/* rtl/sfrhc_pkg.sv */
// Shared types and constants of the SLIP frame receiver with header check.
// No dependencies; used by the decoder core, the top level and the checker.
package sfrhc_pkg;

  // Default frame geometry
  localparam int unsigned DefMaxPayloadBytes = 246;
  localparam int unsigned DefHeaderBytes     = 6;
  localparam int unsigned DefCheckBytes      = 4;

  // SLIP special characters
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Header format fields
  localparam logic [5:0] HDR0_MARK = 6'h3E;
  localparam logic [1:0] HDR1_KIND = 2'b10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 1'b1;

  // Event codes of a result
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DATA       = 3'd1,
    EV_ACCEPT     = 3'd2,
    EV_ERROR      = 3'd3,
    EV_IRRELEVANT = 3'd4,
    EV_SHORT      = 3'd5
  } event_e;

  // One result item
  typedef struct packed {
    logic [31:0] error_count;
    logic [1:0]  priority_res;
    logic [8:0]  frame_length;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    event_e      event_res;
  } result_t;

endpackage

/* rtl/sfrhc_core.sv */
// SLIP decode and header check state: one byte per step, one result per step.
// Depends on sfrhc_pkg.
module sfrhc_core import sfrhc_pkg::*; #(
  parameter int unsigned MaxPayloadBytes = DefMaxPayloadBytes,
  parameter int unsigned HeaderBytes     = DefHeaderBytes,
  parameter int unsigned CheckBytes      = DefCheckBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  output result_t              res_o
);

  localparam int unsigned FrameCap = HeaderBytes + MaxPayloadBytes + CheckBytes;
  localparam int unsigned FrameMin = HeaderBytes + CheckBytes;
  localparam int unsigned PosW     = $clog2(FrameCap + 1);
  localparam logic [PosW-1:0] PosCap   = PosW'(FrameCap);
  localparam logic [PosW-1:0] PosMin   = PosW'(FrameMin);
  localparam logic [PosW-1:0] PosHdr   = PosW'(4);
  localparam logic [PosW-1:0] PosLastH = PosW'(3);

  logic [7:0]      own_q, bcast_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            hunt_q, hunt_d;
  logic            esc_q, esc_d;
  logic [7:0]      hdr_q [4];
  logic [7:0]      hdr_d [4];
  logic [31:0]     err_q, err_d;
  logic [1:0]      err_inc;
  logic            do_store;
  logic [7:0]      store_byte;
  logic            bad0, bad1, irrel;
  result_t         res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= 8'h00;
      bcast_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_ADDR:   own_q   <= cfg_wdata_i;
        CFG_BCAST_ADDR: bcast_q <= cfg_wdata_i;
        default:        own_q   <= own_q;
      endcase
    end
  end

  // Header format tests, valid when the fourth byte is being stored
  assign bad0  = (hdr_q[0][5:0] != HDR0_MARK);
  assign bad1  = (hdr_q[1][5:4] != HDR1_KIND);

  // Next state and result for the byte at the input
  always_comb begin
    pos_d      = pos_q;
    hunt_d     = hunt_q;
    esc_d      = esc_q;
    hdr_d      = hdr_q;
    err_inc    = 2'd0;
    do_store   = 1'b0;
    store_byte = rx_byte_i;
    irrel      = 1'b0;
    res        = '0;
    res.event_res = EV_NONE;

    if (rx_byte_i == SLIP_END) begin
      // frame end or frame start
      if (!hunt_q) begin
        if (pos_q >= PosMin) begin
          if (!esc_q) begin
            res.event_res    = EV_ACCEPT;
            res.frame_length = 9'(pos_q);
            res.priority_res = hdr_q[0][7:6];
          end else begin
            err_inc       = 2'd1;
            res.event_res = EV_ERROR;
          end
        end else if (pos_q != '0 || esc_q) begin
          res.event_res = EV_SHORT;
        end
      end
      hunt_d = 1'b0;
      pos_d  = '0;
      esc_d  = 1'b0;
    end else if (!hunt_q) begin
      if (pos_q >= PosCap) begin
        // overflow
        hunt_d        = 1'b1;
        pos_d         = '0;
        esc_d         = 1'b0;
        err_inc       = 2'd1;
        res.event_res = EV_ERROR;
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (rx_byte_i == SLIP_ESC_END) begin
          do_store   = 1'b1;
          store_byte = SLIP_END;
        end else if (rx_byte_i == SLIP_ESC_ESC) begin
          do_store   = 1'b1;
          store_byte = SLIP_ESC;
        end else begin
          // bad escape
          hunt_d        = 1'b1;
          pos_d         = '0;
          err_inc       = 2'd1;
          res.event_res = EV_ERROR;
        end
      end else if (rx_byte_i == SLIP_ESC) begin
        esc_d = 1'b1;
      end else begin
        do_store = 1'b1;
      end
    end

    // Store a decoded byte; the fourth one triggers the header check
    if (do_store) begin
      if (pos_q < PosHdr) begin
        hdr_d[pos_q[1:0]] = store_byte;
      end
      res.event_res  = EV_DATA;
      res.data_byte  = store_byte;
      res.byte_index = 8'(pos_q);
      pos_d          = pos_q + PosW'(1);
      if (pos_q == PosLastH) begin
        // destination is the byte being stored
        irrel   = (store_byte != own_q) && (store_byte != bcast_q);
        err_inc = 2'(bad0) + 2'(bad1);
        if (bad0 || bad1 || irrel) begin
          hunt_d         = 1'b1;
          pos_d          = '0;
          res.event_res  = (bad0 || bad1) ? EV_ERROR : EV_IRRELEVANT;
          res.data_byte  = 8'h00;
          res.byte_index = 8'h00;
        end
      end
    end

    err_d = err_q + 32'(err_inc);
    res.error_count = err_d;
  end

  // Decoder state, advanced on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hunt_q <= 1'b1;
      esc_q  <= 1'b0;
      hdr_q  <= '{default: 8'h00};
      err_q  <= 32'd0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      hunt_q <= hunt_d;
      esc_q  <= esc_d;
      hdr_q  <= hdr_d;
      err_q  <= err_d;
    end
  end

  assign res_o = res;

endmodule

/* rtl/slip_frame_receiver_with_header_check.sv */
// Top level of the SLIP frame receiver with header check: stream ports,
// output register and skid stage. Depends on sfrhc_pkg and sfrhc_core.
//
// Takes one SLIP encoded byte per transfer and gives exactly one result per
// byte, in order: a decoded data byte with its index, a frame verdict
// (accepted with length and priority, error, dropped as irrelevant, short),
// or nothing, always with the running receive error count. A byte is
// decoded in the cycle of its transfer and its result is registered in the
// output register, or in the skid stage while the output is held. The
// sustained rate is one byte per clock while results are taken; a two-entry
// output buffer keeps the slave side ready while one result waits to be
// taken. Configuration writes land at the next clock edge and are to be
// made only while no byte is in flight.
module slip_frame_receiver_with_header_check import sfrhc_pkg::*; #(
  parameter int unsigned MaxPayloadBytes = DefMaxPayloadBytes,
  parameter int unsigned HeaderBytes     = DefHeaderBytes,
  parameter int unsigned CheckBytes      = DefCheckBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  // receive byte stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,  // [7:0] rx_byte
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [63:0]          m_axis_tdata_o,  // [7:0] data_byte, [15:8] byte_index,
                                                // [24:16] frame_length,
                                                // [26:25] priority_res,
                                                // [58:27] error_count, rest zero
  output logic [2:0]           m_axis_tuser_o   // [2:0] event_res
);

  logic    in_xfer;
  result_t core_res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  sfrhc_core #(
    .MaxPayloadBytes (MaxPayloadBytes),
    .HeaderBytes     (HeaderBytes),
    .CheckBytes      (CheckBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (in_xfer),
    .rx_byte_i   (s_axis_tdata_i),
    .res_o       (core_res)
  );

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload path, no reset
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_xfer) begin
        out_q <= core_res;
      end
    end else if (in_xfer) begin
      skid_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.event_res;
  assign m_axis_tdata_o  = {5'd0, out_q.error_count, out_q.priority_res,
                            out_q.frame_length, out_q.byte_index, out_q.data_byte};

endmodule

/* rtl/sfrhc_checker.sv */
// Port-level assertions for the SLIP frame receiver, bound to the top level.
// Depends on sfrhc_pkg and the shared assertion macro header.
`include "slip_frame_receiver_with_header_check_defines.svh"

module sfrhc_checker import sfrhc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // a waiting result stays offered
  `SFRHC_ASSERT(a_hold_valid, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)

  // data and index fields are zero unless a data byte is shown
  `SFRHC_ASSERT(a_data_zero, m_axis_tvalid_o && m_axis_tuser_o != EV_DATA |-> m_axis_tdata_o[15:0] == 16'd0)

  // length and priority are zero unless a frame is accepted
  `SFRHC_ASSERT(a_len_zero, m_axis_tvalid_o && m_axis_tuser_o != EV_ACCEPT |-> m_axis_tdata_o[26:16] == 11'd0)

  // nothing is offered while in reset
  `SFRHC_ASSERT_RST(a_rst_idle, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind slip_frame_receiver_with_header_check sfrhc_checker u_sfrhc_checker (.*);
